@@ hw/rtl/sat_pkg.sv @@
// ----------------------------------------------------------------------------
// Security association table package
// Operation and status codes, stored entry layout and sequencer states.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 16;

  localparam int OpW     = 2;
  localparam int StatusW = 2;
  localparam int IndexW  = 4;
  localparam int IpW     = 32;

  localparam logic [OpW-1:0] OP_INSERT_IN  = 2'd0;
  localparam logic [OpW-1:0] OP_INSERT_OUT = 2'd1;
  localparam logic [OpW-1:0] OP_LOOKUP_IN  = 2'd2;
  localparam logic [OpW-1:0] OP_LOOKUP_OUT = 2'd3;

  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL     = 2'd1;
  localparam logic [StatusW-1:0] STATUS_MODE_REJ = 2'd2;
  localparam logic [StatusW-1:0] STATUS_MISS     = 2'd3;

  typedef struct packed {
    logic [IpW-1:0] src;
    logic [IpW-1:0] dst;
    logic [IpW-1:0] tun_src;
    logic [IpW-1:0] tun_dst;
    logic [IpW-1:0] spi;
    logic           inbound;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/security_association_table_core.sv @@
// ----------------------------------------------------------------------------
// Security association table core
// Stores tunnel-mode ESP security associations and resolves lookups.
// ----------------------------------------------------------------------------
// An insert beat writes its entry on acceptance, when the table has room and
// modes_ok is set, and its result is then loaded into the result register. A
// lookup steps the single entry comparator through the table RAM one entry
// per cycle, newest first;
// a hit ends the scan early. Only one beat is in progress at a time, and the
// input is not ready while it is. The result register lets a new beat be taken
// while the previous result still waits downstream.
module security_association_table_core #(
  parameter int TABLE_DEPTH = sat_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // src_ip[31:0], dst_ip[63:32], tunnel_src[95:64], tunnel_dst[127:96],
  // spi[159:128], spi_present[160], modes_ok[161], zero fill[167:162]
  input  logic [167:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // entry_index[3:0], zero fill[7:4]
  output logic [7:0]   m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser
);

  localparam int AddrW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CountW = $clog2(TABLE_DEPTH + 1);
  localparam int EntryW = $bits(sat_pkg::entry_t);

  sat_pkg::state_t state, state_next;

  logic [CountW-1:0] entry_count;
  logic [AddrW-1:0]  scan_addr;
  logic [AddrW-1:0]  cmp_addr;
  logic              issue_more;
  logic              rd_vld;

  logic [sat_pkg::OpW-1:0] op;
  logic [31:0]             key_src;
  logic [31:0]             key_dst;
  logic [31:0]             key_spi;
  logic                    key_spi_on;

  logic [sat_pkg::StatusW-1:0] res_status;
  logic [sat_pkg::IndexW-1:0]  res_index;
  logic [sat_pkg::StatusW-1:0] out_status;
  logic [sat_pkg::IndexW-1:0]  out_index;
  logic                        out_valid;

  sat_pkg::entry_t wr_entry;
  sat_pkg::entry_t rd_entry;
  logic [EntryW-1:0] rd_raw;

  logic in_accept;
  logic in_insert;
  logic in_full;
  logic in_mode_ok;
  logic ram_we;
  logic load_out;
  logic lookup_in;
  logic sa_hit;
  logic tun_hit;
  logic entry_hit;
  logic scan_hit;
  logic scan_miss;

  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign in_insert  = (s_axis_tuser == sat_pkg::OP_INSERT_IN) ||
                      (s_axis_tuser == sat_pkg::OP_INSERT_OUT);
  assign in_full    = (entry_count == CountW'(TABLE_DEPTH));
  assign in_mode_ok = s_axis_tdata[161];

  always_comb begin
    wr_entry.src     = s_axis_tdata[31:0];
    wr_entry.dst     = s_axis_tdata[63:32];
    wr_entry.tun_src = s_axis_tdata[95:64];
    wr_entry.tun_dst = s_axis_tdata[127:96];
    wr_entry.spi     = s_axis_tdata[159:128];
    wr_entry.inbound = (s_axis_tuser == sat_pkg::OP_INSERT_IN);
  end

  sat_ram #(
    .WIDTH (EntryW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count[AddrW-1:0]),
    .wdata (wr_entry),
    .raddr (scan_addr),
    .rdata (rd_raw)
  );

  assign rd_entry = sat_pkg::entry_t'(rd_raw);

  // shared entry comparator
  assign lookup_in = (op == sat_pkg::OP_LOOKUP_IN);
  assign sa_hit    = (rd_entry.src == key_src) && (rd_entry.dst == key_dst);
  assign tun_hit   = (rd_entry.tun_src == key_src) && (rd_entry.tun_dst == key_dst);
  always_comb begin
    if (rd_entry.inbound != lookup_in) begin
      entry_hit = 1'b0;
    end else if (lookup_in) begin
      entry_hit = (sa_hit || tun_hit) && (!key_spi_on || (rd_entry.spi == key_spi));
    end else begin
      entry_hit = sa_hit;
    end
  end

  assign scan_hit  = rd_vld && entry_hit;
  assign scan_miss = rd_vld && !entry_hit && (cmp_addr == '0);

  always_comb begin
    state_next = state;
    case (state)
      sat_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_insert || (entry_count == '0)) begin
            state_next = sat_pkg::ST_DONE;
          end else begin
            state_next = sat_pkg::ST_SCAN;
          end
        end
      end
      sat_pkg::ST_SCAN: begin
        if (scan_hit || scan_miss) begin
          state_next = sat_pkg::ST_DONE;
        end
      end
      sat_pkg::ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          state_next = sat_pkg::ST_IDLE;
        end
      end
      default: state_next = sat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    load_out      = 1'b0;
    case (state)
      sat_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_we        = in_accept && in_insert && !in_full && in_mode_ok;
      end
      sat_pkg::ST_SCAN: begin
      end
      sat_pkg::ST_DONE: begin
        load_out = !out_valid || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sat_pkg::ST_IDLE;
      entry_count <= '0;
      issue_more  <= 1'b0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        entry_count <= entry_count + CountW'(1);
      end
      if (state == sat_pkg::ST_SCAN) begin
        rd_vld <= issue_more;
        if (scan_addr == '0) begin
          issue_more <= 1'b0;
        end
      end else begin
        rd_vld     <= 1'b0;
        issue_more <= in_accept && !in_insert && (entry_count != '0);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op         <= s_axis_tuser;
      key_src    <= s_axis_tdata[31:0];
      key_dst    <= s_axis_tdata[63:32];
      key_spi    <= s_axis_tdata[159:128];
      key_spi_on <= s_axis_tdata[160];
      scan_addr  <= AddrW'(entry_count - CountW'(1));
      res_index  <= '0;
      if (in_insert) begin
        if (in_full) begin
          res_status <= sat_pkg::STATUS_FULL;
        end else if (!in_mode_ok) begin
          res_status <= sat_pkg::STATUS_MODE_REJ;
        end else begin
          res_status <= sat_pkg::STATUS_OK;
          res_index  <= sat_pkg::IndexW'(entry_count[AddrW-1:0]);
        end
      end else begin
        res_status <= sat_pkg::STATUS_MISS;
      end
    end else if (state == sat_pkg::ST_SCAN) begin
      cmp_addr <= scan_addr;
      if (issue_more && (scan_addr != '0)) begin
        scan_addr <= scan_addr - AddrW'(1);
      end
      if (scan_hit) begin
        res_status <= sat_pkg::STATUS_OK;
        res_index  <= sat_pkg::IndexW'(cmp_addr);
      end
    end
    if (load_out) begin
      out_status <= res_status;
      out_index  <= res_index;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_index};
  assign m_axis_tuser  = out_status;

endmodule

@@ hw/rtl/sat_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ test/sat_result_checker.sv @@
// ----------------------------------------------------------------------------
// Security association table result checker
// Watches both stream channels of the table core. Each accepted input beat is
// run through a cycle-free model of the table that predicts the status and
// entry index. Each accepted output beat is compared with the oldest
// prediction still waiting. Mismatches and the number of predictions still
// waiting go to the testbench top.
// ----------------------------------------------------------------------------
module sat_result_checker
  import sat_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // src_ip, dst_ip, tunnel_src, tunnel_dst, spi, spi_present, modes_ok, zero fill
  input  logic [167:0] s_axis_tdata,
  // operation
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // entry_index, zero fill
  input  logic [7:0]   m_axis_tdata,
  // status
  input  logic [1:0]   m_axis_tuser,
  output int           errors,
  output int           pending,
  output int           n_stored,
  output int           n_full,
  output int           n_rejected,
  output int           n_hits,
  output int           n_misses
);

  localparam int DEPTH = TABLE_DEPTH_DEFAULT;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IndexW-1:0]  index;
  } sa_verdict_t;

  entry_t      sa_table [DEPTH];
  int          sa_count;
  sa_verdict_t verdicts_due [$];

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("%0t: %s", $time, msg);
  endtask

  function automatic sa_verdict_t resolve_sa(input logic [OpW-1:0] op,
                                             input logic [167:0] beat);
    sa_verdict_t    v;
    entry_t         e;
    logic [IpW-1:0] src;
    logic [IpW-1:0] dst;
    logic [IpW-1:0] spi;
    logic           spi_on;
    logic           modes_ok;
    logic           inbound;
    logic           pair_hit;
    int             k;
    src      = beat[31:0];
    dst      = beat[63:32];
    spi      = beat[159:128];
    spi_on   = beat[160];
    modes_ok = beat[161];
    v.status = STATUS_OK;
    v.index  = '0;
    if (op == OP_INSERT_IN || op == OP_INSERT_OUT) begin
      if (sa_count >= DEPTH) begin
        v.status = STATUS_FULL;
      end else if (!modes_ok) begin
        v.status = STATUS_MODE_REJ;
      end else begin
        e.src     = src;
        e.dst     = dst;
        e.tun_src = beat[95:64];
        e.tun_dst = beat[127:96];
        e.spi     = spi;
        e.inbound = (op == OP_INSERT_IN);
        sa_table[sa_count] = e;
        v.index = IndexW'(sa_count);
        sa_count++;
      end
    end else begin
      inbound  = (op == OP_LOOKUP_IN);
      v.status = STATUS_MISS;
      for (k = sa_count - 1; k >= 0; k--) begin
        e = sa_table[k];
        pair_hit = (e.src == src && e.dst == dst) ||
                   (inbound && e.tun_src == src && e.tun_dst == dst);
        if (e.inbound == inbound && pair_hit &&
            !(inbound && spi_on && e.spi != spi)) begin
          v.status = STATUS_OK;
          v.index  = IndexW'(k);
          break;
        end
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    sa_verdict_t want;
    if (rst) begin
      sa_count   = 0;
      verdicts_due.delete();
      pending    = 0;
      errors     = 0;
      n_stored   = 0;
      n_full     = 0;
      n_rejected = 0;
      n_hits     = 0;
      n_misses   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding: status %0d index %0d",
                                    m_axis_tuser, m_axis_tdata[IndexW-1:0]));
        end else begin
          want = verdicts_due.pop_front();
          if (m_axis_tuser !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", m_axis_tuser, want.status));
          if (m_axis_tdata[IndexW-1:0] !== want.index)
            report_mismatch($sformatf("entry_index %0d, expected %0d",
                                      m_axis_tdata[IndexW-1:0], want.index));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = resolve_sa(s_axis_tuser, s_axis_tdata);
        verdicts_due.push_back(want);
        case (want.status)
          STATUS_FULL:     n_full++;
          STATUS_MODE_REJ: n_rejected++;
          STATUS_MISS:     n_misses++;
          default: begin
            if (s_axis_tuser == OP_LOOKUP_IN || s_axis_tuser == OP_LOOKUP_OUT) n_hits++;
            else n_stored++;
          end
        endcase
      end
      pending = verdicts_due.size();
    end
  end

endmodule

@@ test/tb_security_association_table_core.sv @@
// ----------------------------------------------------------------------------
// Security association table core testbench
// Drives insert and lookup beats into the table core: a short directed run
// over empty-table misses, mode rejects, direction, tunnel-pair and SPI
// matching and newest-entry priority, then random traffic that mostly looks up
// stored associations, fills the table and keeps inserting past full. Both
// sides idle at random, and the receiver holds off once for a long stretch.
// The checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_security_association_table_core;
  import sat_pkg::*;

  localparam int DEPTH     = TABLE_DEPTH_DEFAULT;
  localparam int N_RANDOM  = 1890;
  localparam int HOLD_AT   = 3000;
  localparam int HOLD_LEN  = 400;
  localparam int STEADY_LO = 10000;
  localparam int STEADY_HI = 14000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  int errors;
  int pending;
  int n_stored;
  int n_full;
  int n_rejected;
  int n_hits;
  int n_misses;

  bit             steady_sender = 1'b0;
  logic [IpW-1:0] pool_src  [DEPTH];
  logic [IpW-1:0] pool_dst  [DEPTH];
  logic [IpW-1:0] pool_tsrc [DEPTH];
  logic [IpW-1:0] pool_tdst [DEPTH];
  logic [IpW-1:0] pool_spi  [DEPTH];
  bit             pool_in   [DEPTH];
  int             pool_n = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  security_association_table_core #(.TABLE_DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  sat_result_checker sa_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors        (errors),
    .pending       (pending),
    .n_stored      (n_stored),
    .n_full        (n_full),
    .n_rejected    (n_rejected),
    .n_hits        (n_hits),
    .n_misses      (n_misses)
  );

  task automatic send_beat(input logic [OpW-1:0] op, input logic [167:0] beat);
    @(negedge clk);
    while (!steady_sender && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= beat;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic insert_sa(input logic [OpW-1:0] op, input logic [IpW-1:0] src,
                           input logic [IpW-1:0] dst, input logic [IpW-1:0] tsrc,
                           input logic [IpW-1:0] tdst, input logic [IpW-1:0] spi,
                           input logic modes_ok);
    send_beat(op, {6'b0, modes_ok, 1'($urandom_range(0, 1)), spi, tdst, tsrc, dst, src});
    if (modes_ok && pool_n < DEPTH) begin
      pool_src[pool_n]  = src;
      pool_dst[pool_n]  = dst;
      pool_tsrc[pool_n] = tsrc;
      pool_tdst[pool_n] = tdst;
      pool_spi[pool_n]  = spi;
      pool_in[pool_n]   = (op == OP_INSERT_IN);
      pool_n++;
    end
  endtask

  task automatic lookup_sa(input logic [OpW-1:0] op, input logic [IpW-1:0] src,
                           input logic [IpW-1:0] dst, input logic [IpW-1:0] spi,
                           input logic spi_on);
    send_beat(op, {6'b0, 1'($urandom_range(0, 1)), spi_on, spi,
                   32'($urandom), 32'($urandom), dst, src});
  endtask

  initial begin : sink
    int cyc;
    int hold;
    cyc  = 0;
    hold = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == HOLD_AT) hold = HOLD_LEN;
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (cyc >= STEADY_LO && cyc < STEADY_HI) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 29);
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("Timed out with %0d results outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [OpW-1:0] op;
    logic [IpW-1:0] src;
    logic [IpW-1:0] dst;
    logic [IpW-1:0] tsrc;
    logic [IpW-1:0] tdst;
    logic [IpW-1:0] spi;
    logic           spi_on;
    int             i;
    int             j;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table, mode reject, then newest-first and tunnel/SPI matching
    lookup_sa(OP_LOOKUP_IN, '0, '0, '0, 1'b1);
    lookup_sa(OP_LOOKUP_OUT, '1, '1, '1, 1'b0);
    insert_sa(OP_INSERT_IN, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
    insert_sa(OP_INSERT_IN, '0, '0, '1, '1, '0, 1'b1);
    insert_sa(OP_INSERT_OUT, '1, '1, '0, '0, '1, 1'b1);
    insert_sa(OP_INSERT_IN, '0, '0, 32'h0a00_0001, 32'h0a00_0002, 32'h1234_5678, 1'b1);
    lookup_sa(OP_LOOKUP_IN, '0, '0, $urandom, 1'b0);
    lookup_sa(OP_LOOKUP_IN, '0, '0, '0, 1'b1);
    lookup_sa(OP_LOOKUP_IN, '1, '1, '0, 1'b1);
    lookup_sa(OP_LOOKUP_IN, 32'h0a00_0001, 32'h0a00_0002, 32'h1234_5678, 1'b1);
    lookup_sa(OP_LOOKUP_IN, 32'h0a00_0001, 32'h0a00_0002, '1, 1'b1);
    lookup_sa(OP_LOOKUP_OUT, '1, '1, $urandom, 1'b1);
    lookup_sa(OP_LOOKUP_OUT, '0, '0, '1, 1'b0);
    insert_sa(OP_INSERT_OUT, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);

    for (i = 0; i < N_RANDOM; i++) begin
      steady_sender = (i >= 700 && i < 1000);
      src    = $urandom;
      dst    = $urandom;
      tsrc   = $urandom;
      tdst   = $urandom;
      spi    = $urandom;
      spi_on = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 15) begin
        op = $urandom_range(0, 1) ? OP_INSERT_OUT : OP_INSERT_IN;
        // reuse stored pairs so that several entries match one lookup
        if (pool_n > 0 && $urandom_range(0, 99) < 30) begin
          j   = $urandom_range(0, pool_n - 1);
          src = pool_src[j];
          dst = pool_dst[j];
        end
        if (pool_n > 0 && $urandom_range(0, 99) < 20) begin
          j    = $urandom_range(0, pool_n - 1);
          tsrc = pool_src[j];
          tdst = pool_dst[j];
        end
        if ($urandom_range(0, 99) < 15) spi = '0;
        insert_sa(op, src, dst, tsrc, tdst, spi, $urandom_range(0, 99) < 80);
      end else begin
        op = $urandom_range(0, 1) ? OP_LOOKUP_OUT : OP_LOOKUP_IN;
        if (pool_n > 0 && $urandom_range(0, 99) < 85) begin
          j = $urandom_range(0, pool_n - 1);
          if ($urandom_range(0, 99) < 75) op = pool_in[j] ? OP_LOOKUP_IN : OP_LOOKUP_OUT;
          if ($urandom_range(0, 99) < 35) begin
            src = pool_tsrc[j];
            dst = pool_tdst[j];
          end else begin
            src = pool_src[j];
            dst = pool_dst[j];
          end
          if ($urandom_range(0, 99) < 75) spi = pool_spi[j];
        end
        lookup_sa(op, src, dst, spi, spi_on);
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (24) @(negedge clk);

    $display("Inserts: %0d stored, %0d refused as full, %0d refused for mode",
             n_stored, n_full, n_rejected);
    $display("Lookups: %0d hits, %0d misses; %0d mismatches", n_hits, n_misses, errors);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
